// ===== rtl/core/sset_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the stable sorted entry table.
// No dependencies; used by sset_ctrl, sset_dp and the top level.
package sset_pkg;

    localparam int TAG_W = 64;
    localparam int LVL_W = 32;

    // opcodes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_TAIL,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic signed [LVL_W-1:0] level;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic       load;        // latch item, restart walk
        logic       walk;        // slot walk active
        logic       tail;        // write tail slot, grow table
        logic       emit;        // push single response item
        logic       set_status;
        logic [1:0] status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       occ_zero;
        logic       occ_full;
        logic       walk_last;   // last slot processed this cycle
        logic       out_free;    // output register can take an item
        logic [1:0] op;          // latched opcode
    } t_stat;

endpackage

// ===== rtl/core/sset_ctrl.sv =====
`timescale 1ns / 1ps
// Operation sequencer for the sorted entry table.
// Depends on sset_pkg; drives sset_dp through t_cmd, reads t_stat.
module sset_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_opcode,
    input  sset_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output sset_pkg::t_cmd  o_cmd
);

    sset_pkg::t_state r_state;
    sset_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sset_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sset_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        sset_pkg::OP_APPEND: begin
                            n_state = i_stat.occ_full ? sset_pkg::S_RESP : sset_pkg::S_TAIL;
                        end
                        sset_pkg::OP_INSERT: begin
                            if (i_stat.occ_full) begin
                                n_state = sset_pkg::S_RESP;
                            end else if (i_stat.occ_zero) begin
                                n_state = sset_pkg::S_TAIL;
                            end else begin
                                n_state = sset_pkg::S_WALK;
                            end
                        end
                        default: begin
                            // delete and read-out
                            n_state = i_stat.occ_zero ? sset_pkg::S_RESP : sset_pkg::S_WALK;
                        end
                    endcase
                end
            end
            sset_pkg::S_WALK: begin
                if (i_stat.walk_last) begin
                    case (i_stat.op)
                        sset_pkg::OP_INSERT: n_state = sset_pkg::S_TAIL;
                        sset_pkg::OP_DELETE: n_state = sset_pkg::S_RESP;
                        default:             n_state = sset_pkg::S_IDLE;
                    endcase
                end
            end
            sset_pkg::S_TAIL: begin
                n_state = sset_pkg::S_RESP;
            end
            sset_pkg::S_RESP: begin
                if (i_stat.out_free) begin
                    n_state = sset_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sset_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            sset_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    if (i_stat.occ_full &&
                        (i_opcode == sset_pkg::OP_APPEND || i_opcode == sset_pkg::OP_INSERT)) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = sset_pkg::ST_FULL;
                    end
                    if (i_stat.occ_zero &&
                        (i_opcode == sset_pkg::OP_DELETE || i_opcode == sset_pkg::OP_READ)) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = sset_pkg::ST_EMPTY;
                    end
                end
            end
            sset_pkg::S_WALK: begin
                o_cmd.walk = 1'b1;
            end
            sset_pkg::S_TAIL: begin
                o_cmd.tail = 1'b1;
            end
            sset_pkg::S_RESP: begin
                o_cmd.emit = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/sset_dp.sv =====
`timescale 1ns / 1ps
// Datapath: slot memory, walk pointers, shift carry, occupancy, output register.
// Depends on sset_pkg; commanded by sset_ctrl.
module sset_dp #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  sset_pkg::t_cmd                   i_cmd,
    input  logic [1:0]                       i_opcode,
    input  logic [sset_pkg::TAG_W-1:0]       i_entry_tag,
    input  logic signed [sset_pkg::LVL_W-1:0] i_entry_level,
    input  logic                             i_out_ready,
    output sset_pkg::t_stat                  o_stat,
    output logic                             o_out_valid,
    output logic [sset_pkg::TAG_W-1:0]       o_out_tag,
    output logic signed [sset_pkg::LVL_W-1:0] o_out_level,
    output logic                             o_last_of_run,
    output logic [1:0]                       o_status
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = IW + 1;

    sset_pkg::t_entry r_mem [TABLE_DEPTH];
    sset_pkg::t_entry r_rdata;
    sset_pkg::t_entry r_carry;

    logic [1:0]                        r_op;
    logic [sset_pkg::TAG_W-1:0]        r_tag;
    logic signed [sset_pkg::LVL_W-1:0] r_level;
    logic [CW-1:0]                     r_occ;
    logic [CW-1:0]                     r_rd_ptr;
    logic [IW-1:0]                     r_pr_ptr;
    logic                              r_pr_valid;
    logic                              r_found;
    logic [1:0]                        r_status;

    logic                              r_out_valid;
    logic [sset_pkg::TAG_W-1:0]        r_out_tag;
    logic signed [sset_pkg::LVL_W-1:0] r_out_level;
    logic                              r_out_last;
    logic [1:0]                        r_out_status;

    logic             out_free;
    logic             is_read;
    logic             stall;
    logic             issue;
    logic             proc;
    logic             pr_last;
    logic             walk_last;
    logic             above;
    logic             match;
    logic             n_found;
    logic             we;
    logic [IW-1:0]    wa;
    sset_pkg::t_entry wd;
    sset_pkg::t_entry new_ent;

    assign new_ent.tag   = r_tag;
    assign new_ent.level = r_level;

    assign out_free  = !r_out_valid || i_out_ready;
    assign is_read   = (r_op == sset_pkg::OP_READ);
    // read-out waits on a busy output register; rdata holds meanwhile
    assign stall     = i_cmd.walk && r_pr_valid && is_read && !out_free;
    assign issue     = i_cmd.walk && !stall && (r_rd_ptr < r_occ);
    assign proc      = i_cmd.walk && r_pr_valid && !stall;
    assign pr_last   = ({1'b0, r_pr_ptr} == (r_occ - CW'(1)));
    assign walk_last = proc && pr_last;
    assign above     = ($signed(r_rdata.level) > r_level);
    assign match     = (r_rdata.tag == r_tag);

    // slot write selection; at most one writer per cycle
    always_comb begin
        we      = 1'b0;
        wa      = r_pr_ptr;
        wd      = new_ent;
        n_found = r_found;
        if (proc) begin
            case (r_op)
                sset_pkg::OP_INSERT: begin
                    if (r_found) begin
                        we = 1'b1;
                        wd = r_carry;
                    end else if (above) begin
                        we      = 1'b1;
                        wd      = new_ent;
                        n_found = 1'b1;
                    end
                end
                sset_pkg::OP_DELETE: begin
                    if (r_found) begin
                        we = 1'b1;
                        wa = r_pr_ptr - IW'(1);
                        wd = r_rdata;
                    end else if (match) begin
                        n_found = 1'b1;
                    end
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end else if (i_cmd.tail) begin
            we = 1'b1;
            wa = r_occ[IW-1:0];
            wd = r_found ? r_carry : new_ent;
        end
    end

    // slot memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (issue) begin
            r_rdata <= r_mem[r_rd_ptr[IW-1:0]];
        end
    end

    // payload latch and carry
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_tag   <= i_entry_tag;
            r_level <= i_entry_level;
        end
        if (proc && r_op == sset_pkg::OP_INSERT && (r_found || above)) begin
            r_carry <= r_rdata;
        end
        if (i_cmd.walk && !stall) begin
            r_pr_ptr <= r_rd_ptr[IW-1:0];
        end
    end

    // walk and table control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_rd_ptr   <= '0;
            r_pr_valid <= 1'b0;
            r_found    <= 1'b0;
            r_status   <= sset_pkg::ST_OK;
        end else begin
            if (i_cmd.load) begin
                r_rd_ptr   <= '0;
                r_pr_valid <= 1'b0;
                r_found    <= 1'b0;
            end else if (i_cmd.walk && !stall) begin
                r_pr_valid <= issue;
                r_found    <= n_found;
                if (issue) begin
                    r_rd_ptr <= r_rd_ptr + CW'(1);
                end
            end
            if (i_cmd.set_status) begin
                r_status <= i_cmd.status;
            end
            if (walk_last && r_op == sset_pkg::OP_DELETE) begin
                if (n_found) begin
                    r_occ    <= r_occ - CW'(1);
                    r_status <= sset_pkg::ST_OK;
                end else begin
                    r_status <= sset_pkg::ST_MISSING;
                end
            end
            if (i_cmd.tail) begin
                r_occ    <= r_occ + CW'(1);
                r_status <= sset_pkg::ST_OK;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || (proc && is_read)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_tag    <= '0;
            r_out_level  <= '0;
            r_out_last   <= 1'b1;
            r_out_status <= r_status;
        end else if (proc && is_read) begin
            r_out_tag    <= r_rdata.tag;
            r_out_level  <= r_rdata.level;
            r_out_last   <= pr_last;
            r_out_status <= sset_pkg::ST_OK;
        end
    end

    assign o_stat.occ_zero  = (r_occ == '0);
    assign o_stat.occ_full  = (r_occ == CW'(TABLE_DEPTH));
    assign o_stat.walk_last = walk_last;
    assign o_stat.out_free  = out_free;
    assign o_stat.op        = r_op;

    assign o_out_valid   = r_out_valid;
    assign o_out_tag     = r_out_tag;
    assign o_out_level   = r_out_level;
    assign o_last_of_run = r_out_last;
    assign o_status      = r_out_status;

endmodule

// ===== rtl/core/stable_sorted_entry_table_unit.sv =====
`timescale 1ns / 1ps
// Items are taken one at a time: input ready is high only while the sequencer is idle. A full
// or empty answer skips the walk; read-out gives one item per cycle while the output register
// is free. The walk goes over the slot memory through its single read port.
// Reset (sync, active low) empties the table; slot contents stay undefined until written.
// Depends on sset_pkg, sset_ctrl, sset_dp.
module stable_sorted_entry_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [sset_pkg::TAG_W-1:0]        i_entry_tag,
    input  logic signed [sset_pkg::LVL_W-1:0] i_entry_level,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [sset_pkg::TAG_W-1:0]        o_out_tag,
    output logic signed [sset_pkg::LVL_W-1:0] o_out_level,
    output logic                              o_last_of_run,
    output logic [1:0]                        o_status
);

    // Walk: one slot read issued per cycle unless stalled; data is processed from rdata.
    //   insert - first slot with a higher level takes the new item; each later slot
    //            takes the carried one; the last carry lands in the tail slot.
    //   delete - after the first tag match every slot moves down by one.
    //   read   - each slot goes straight to the output register, stalling on it.
    // The output register lets the next item come in while a result waits.

    sset_pkg::t_cmd  cmd;
    sset_pkg::t_stat stat;

    sset_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    sset_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_opcode      (i_opcode),
        .i_entry_tag   (i_entry_tag),
        .i_entry_level (i_entry_level),
        .i_out_ready   (i_out_ready),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_out_tag     (o_out_tag),
        .o_out_level   (o_out_level),
        .o_last_of_run (o_last_of_run),
        .o_status      (o_status)
    );

    // table can't be empty and full at once
    a_occ_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.occ_zero && stat.occ_full))
        else $error("occupancy both empty and full");

    // one item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while previous one in flight");

    // tail write never on a full table
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.tail |-> !stat.occ_full)
        else $error("tail write on full table");

endmodule
